// ===== design/rau_pkg.sv =====
// Shared types, constants and helpers of the rational arithmetic unit.
package rau_pkg;

	localparam int NUM_WIDTH   = 32;
	localparam int FIELD_W     = 32;
	localparam int MAG_W       = 2 * NUM_WIDTH;
	localparam int CNT_W       = $clog2(MAG_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (NUM_WIDTH - 1);
	localparam logic [MAG_W-1:0] LIM_POS = LIM_NEG - MAG_W'(1);

	typedef enum logic [2:0] {
		CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_LT, CMD_GT, CMD_EQ, CMD_NE
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_ZDEN = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                      cmd;
		logic signed [FIELD_W-1:0] num_a;
		logic signed [FIELD_W-1:0] den_a;
		logic signed [FIELD_W-1:0] num_b;
		logic signed [FIELD_W-1:0] den_b;
	} rau_in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] res_num;
		logic signed [FIELD_W-1:0] res_den;
		logic                      compare_true;
		status_t                   status;
	} rau_out_t;

	// Classified item: three magnitude products p = x * y with sign s.
	// Numerator (or difference for compares) is p0 + p1, denominator is p2.
	typedef struct packed {
		cmd_t                 cmd;
		logic                 cmp;
		logic                 zden;
		logic                 flip;
		logic [NUM_WIDTH-1:0] x0;
		logic [NUM_WIDTH-1:0] y0;
		logic                 s0;
		logic [NUM_WIDTH-1:0] x1;
		logic [NUM_WIDTH-1:0] y1;
		logic                 s1;
		logic [NUM_WIDTH-1:0] x2;
		logic [NUM_WIDTH-1:0] y2;
		logic                 s2;
	} rau_job_t;

	typedef enum logic [3:0] {
		B_IDLE, B_MUL0, B_MUL1, B_MUL2, B_SUM, B_DEC,
		B_STRIP, B_AODD, B_GCD, B_DIV, B_FIT, B_OUT
	} back_state_t;

	// Signed magnitude to output field: wrap to NUM_WIDTH, sign-extend.
	function automatic logic signed [FIELD_W-1:0] to_field(input logic neg,
			input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0]            v;
		logic signed [NUM_WIDTH-1:0] t;
		v = neg ? (~mag + MAG_W'(1)) : mag;
		t = v[NUM_WIDTH-1:0];
		return FIELD_W'(t);
	endfunction

endpackage

// ===== design/rau_front.sv =====
// Front end: accepts items, decodes the command and sets up the products.
module rau_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_stall,
	input  rau_pkg::rau_in_t  op,
	output logic              job_valid,
	input  logic              job_stall,
	output rau_pkg::rau_job_t job
);
	import rau_pkg::*;

	logic [NUM_WIDTH-1:0] na_w, da_w, nb_w, db_w;
	logic [NUM_WIDTH-1:0] na_m, da_m, nb_m, db_m;
	logic                 na_n, da_n, nb_n, db_n, rneg;
	logic [NUM_WIDTH-1:0] one_w;
	rau_job_t             cls;
	rau_job_t             job_q;
	logic                 valid_q;

	assign na_w  = op.num_a[NUM_WIDTH-1:0];
	assign da_w  = op.den_a[NUM_WIDTH-1:0];
	assign nb_w  = op.num_b[NUM_WIDTH-1:0];
	assign db_w  = op.den_b[NUM_WIDTH-1:0];
	assign na_n  = na_w[NUM_WIDTH-1];
	assign da_n  = da_w[NUM_WIDTH-1];
	assign nb_n  = nb_w[NUM_WIDTH-1];
	assign db_n  = db_w[NUM_WIDTH-1];
	assign na_m  = na_n ? (~na_w + NUM_WIDTH'(1)) : na_w;
	assign da_m  = da_n ? (~da_w + NUM_WIDTH'(1)) : da_w;
	assign nb_m  = nb_n ? (~nb_w + NUM_WIDTH'(1)) : nb_w;
	assign db_m  = db_n ? (~db_w + NUM_WIDTH'(1)) : db_w;
	assign one_w = NUM_WIDTH'(1);
	assign rneg  = nb_n ^ (op.cmd == CMD_SUB);

	always_comb begin
		cls     = '0;
		cls.cmd = op.cmd;
		unique case (op.cmd)
			CMD_ADD, CMD_SUB: begin
				if (da_w == db_w) begin
					cls.x0 = na_m; cls.y0 = one_w; cls.s0 = na_n;
					cls.x1 = nb_m; cls.y1 = one_w; cls.s1 = rneg;
					cls.x2 = da_m; cls.y2 = one_w; cls.s2 = da_n;
				end else begin
					cls.x0 = na_m; cls.y0 = db_m; cls.s0 = na_n ^ db_n;
					cls.x1 = nb_m; cls.y1 = da_m; cls.s1 = rneg ^ da_n;
					cls.x2 = da_m; cls.y2 = db_m; cls.s2 = da_n ^ db_n;
				end
			end
			CMD_MUL: begin
				cls.x0 = na_m; cls.y0 = nb_m; cls.s0 = na_n ^ nb_n;
				cls.x2 = da_m; cls.y2 = db_m; cls.s2 = da_n ^ db_n;
			end
			CMD_DIV: begin
				cls.x0 = na_m; cls.y0 = db_m; cls.s0 = na_n ^ db_n;
				cls.x2 = da_m; cls.y2 = nb_m; cls.s2 = da_n ^ nb_n;
			end
			default: begin
				// compare: difference na*db - nb*da
				cls.cmp  = 1'b1;
				cls.zden = (da_w == '0) || (db_w == '0);
				cls.flip = da_n ^ db_n;
				cls.x0 = na_m; cls.y0 = db_m; cls.s0 = na_n ^ db_n;
				cls.x1 = nb_m; cls.y1 = da_m; cls.s1 = !(nb_n ^ da_n);
			end
		endcase
	end

	assign op_stall  = valid_q && job_stall;
	assign job_valid = valid_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!op_stall) begin
			valid_q <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && !op_stall) begin
			job_q <= cls;
		end
	end

endmodule

// ===== design/rau_queue.sv =====
// Short queue between front and back end.
module rau_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_stall,
	input  rau_pkg::rau_job_t push_job,
	output logic              pop_valid,
	input  logic              pop_stall,
	output rau_pkg::rau_job_t pop_job
);
	import rau_pkg::*;

	rau_job_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push, pop;

	assign push_stall = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)      count_q <= count_q + (PTR_W+1)'(1);
			else if (pop && !push) count_q <= count_q - (PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |=> !$past(pop))
		else $error("pop from empty queue");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == (PTR_W+1)'(QUEUE_DEPTH) && !pop) |=> $stable(count_q))
		else $error("count moved while full and not popped");

endmodule

// ===== design/rau_back.sv =====
// Back end: products, sum, binary GCD, restoring division and output register.
module rau_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_stall,
	input  rau_pkg::rau_job_t job,
	output logic              res_valid,
	input  logic              res_stall,
	output rau_pkg::rau_out_t res
);
	import rau_pkg::*;

	back_state_t          state_q, state_d;
	rau_job_t             job_q;
	logic [MAG_W-1:0]     p0_q, p1_q, p2_q;
	logic [MAG_W-1:0]     n_mag_q, d_mag_q;
	logic                 n_neg_q, d_neg_q;
	logic [MAG_W-1:0]     a_q, b_q;
	logic [CNT_W-1:0]     k_q, cnt_q;
	logic [MAG_W-1:0]     qn_q, qd_q;
	logic [MAG_W:0]       rn_q, rd_q;
	rau_out_t             rslt_q, res_q;
	logic                 res_valid_q;

	logic [NUM_WIDTH-1:0] mul_a, mul_b;
	logic [MAG_W-1:0]     mul_p;
	logic                 an, bn, s_neg;
	logic [MAG_W-1:0]     s_mag;
	logic                 lt0, gt0, eq0, lt, gt;
	rau_out_t             dec_rslt, fit_rslt;
	logic [MAG_W:0]       tn, td, dv;
	logic                 out_load;

	// one shared multiplier
	always_comb begin
		unique case (state_q)
			B_MUL0:  begin mul_a = job_q.x0; mul_b = job_q.y0; end
			B_MUL1:  begin mul_a = job_q.x1; mul_b = job_q.y1; end
			default: begin mul_a = job_q.x2; mul_b = job_q.y2; end
		endcase
		mul_p = MAG_W'(mul_a) * MAG_W'(mul_b);
	end

	// signed-magnitude add of p0 and p1
	always_comb begin
		an = job_q.s0 && (p0_q != '0);
		bn = job_q.s1 && (p1_q != '0);
		if (an == bn) begin
			s_mag = p0_q + p1_q;
			s_neg = an;
		end else if (p0_q >= p1_q) begin
			s_mag = p0_q - p1_q;
			s_neg = an;
		end else begin
			s_mag = p1_q - p0_q;
			s_neg = bn;
		end
		if (s_mag == '0) s_neg = 1'b0;
	end

	always_comb begin
		lt0 = n_neg_q;
		eq0 = (n_mag_q == '0);
		gt0 = !n_neg_q && !eq0;
		lt  = job_q.flip ? gt0 : lt0;
		gt  = job_q.flip ? lt0 : gt0;
		dec_rslt = '0;
		if (job_q.cmp) begin
			if (job_q.zden) begin
				dec_rslt.status = ST_ZDEN;
			end else begin
				unique case (job_q.cmd)
					CMD_LT:  dec_rslt.compare_true = lt;
					CMD_GT:  dec_rslt.compare_true = gt;
					CMD_EQ:  dec_rslt.compare_true = eq0;
					default: dec_rslt.compare_true = !eq0;
				endcase
			end
		end else if (d_mag_q == '0) begin
			dec_rslt.status  = ST_ZDEN;
			dec_rslt.res_num = to_field(n_neg_q, n_mag_q);
		end else begin
			// zero numerator reduces to 0 over plus or minus one
			dec_rslt.res_den = to_field(d_neg_q, MAG_W'(1));
		end
	end

	always_comb begin
		fit_rslt = '0;
		if ((n_neg_q ? (qn_q <= LIM_NEG) : (qn_q <= LIM_POS)) &&
				(d_neg_q ? (qd_q <= LIM_NEG) : (qd_q <= LIM_POS))) begin
			fit_rslt.res_num = to_field(n_neg_q, qn_q);
			fit_rslt.res_den = to_field(d_neg_q, qd_q);
		end else begin
			fit_rslt.status = ST_OVF;
		end
	end

	// restoring division trial, both quotients at once
	assign dv = {1'b0, a_q};
	assign tn = {rn_q[MAG_W-1:0], qn_q[MAG_W-1]};
	assign td = {rd_q[MAG_W-1:0], qd_q[MAG_W-1]};

	assign out_load  = (state_q == B_OUT) && (!res_valid_q || !res_stall);
	assign job_stall = (state_q != B_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (job_valid) state_d = B_MUL0;
			B_MUL0:  state_d = B_MUL1;
			B_MUL1:  state_d = B_MUL2;
			B_MUL2:  state_d = B_SUM;
			B_SUM:   state_d = B_DEC;
			B_DEC: begin
				if (job_q.cmp || d_mag_q == '0 || n_mag_q == '0) state_d = B_OUT;
				else state_d = B_STRIP;
			end
			B_STRIP: if (a_q[0] || b_q[0]) state_d = B_AODD;
			B_AODD:  if (a_q[0]) state_d = B_GCD;
			B_GCD:   if (b_q == '0) state_d = B_DIV;
			B_DIV:   if (cnt_q == '0) state_d = B_FIT;
			B_FIT:   state_d = B_OUT;
			B_OUT:   if (out_load) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
			if (out_load) res_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) res_q <= rslt_q;
		case (state_q)
			B_IDLE: if (job_valid) job_q <= job;
			B_MUL0: p0_q <= mul_p;
			B_MUL1: p1_q <= mul_p;
			B_MUL2: p2_q <= mul_p;
			B_SUM: begin
				n_mag_q <= s_mag;
				n_neg_q <= s_neg;
				d_mag_q <= p2_q;
				d_neg_q <= job_q.s2 && (p2_q != '0);
			end
			B_DEC: begin
				a_q    <= n_mag_q;
				b_q    <= d_mag_q;
				k_q    <= '0;
				rslt_q <= dec_rslt;
			end
			B_STRIP: begin
				if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + CNT_W'(1);
				end
			end
			B_AODD: if (!a_q[0]) a_q <= a_q >> 1;
			B_GCD: begin
				if (b_q == '0) begin
					// gcd = a << k, so divide the k-shifted values by a
					qn_q  <= n_mag_q >> k_q;
					qd_q  <= d_mag_q >> k_q;
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= CNT_W'(MAG_W - 1);
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q > b_q) begin
					a_q <= b_q;
					b_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			B_DIV: begin
				if (tn >= dv) begin
					rn_q <= tn - dv;
					qn_q <= {qn_q[MAG_W-2:0], 1'b1};
				end else begin
					rn_q <= tn;
					qn_q <= {qn_q[MAG_W-2:0], 1'b0};
				end
				if (td >= dv) begin
					rd_q <= td - dv;
					qd_q <= {qd_q[MAG_W-2:0], 1'b1};
				end else begin
					rd_q <= td;
					qd_q <= {qd_q[MAG_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
			B_FIT: rslt_q <= fit_rslt;
			default: ;
		endcase
	end

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_OVF) |->
			(res_q.res_num == '0 && res_q.res_den == '0))
		else $error("overflow result not cleared");

	a_flag_no_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != ST_OK) |-> !res_q.compare_true)
		else $error("compare flag set on flagged item");

	a_gcd_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_GCD) |-> a_q[0])
		else $error("gcd loop entered with even a");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (a_q != '0))
		else $error("division by zero gcd");

endmodule

// ===== design/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: front end, queue and back end.
// Compares, zero denominators and zero numerators go from the decode state to the output state;
// reduced results also pass through the binary GCD loop
// (one shift or subtract a cycle over 64-bit magnitudes) and the 64-step division.
// Throughput: one item per back-end run; the queue and the front register hold three more.
// Reset: arst_n clears all valid flags, the queue and the back-end state at once.
module rational_arithmetic_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_stall,
	input  rau_pkg::rau_in_t op,
	output logic             res_valid,
	input  logic             res_stall,
	output rau_pkg::rau_out_t res
);
	import rau_pkg::*;

	// front to queue
	logic     fq_valid, fq_stall;
	rau_job_t fq_job;
	// queue to back end
	logic     qb_valid, qb_stall;
	rau_job_t qb_job;

	// Front end decodes the command and lines up three products per item.
	rau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op        (op),
		.job_valid (fq_valid),
		.job_stall (fq_stall),
		.job       (fq_job)
	);

	// Two-entry queue decouples the front from the long back-end run.
	rau_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_stall (fq_stall),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_stall  (qb_stall),
		.pop_job    (qb_job)
	);

	// Back end: shared multiplier, GCD reduction, division, output register.
	rau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_stall (qb_stall),
		.job       (qb_job),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== tb/sv/tb_rational_arithmetic_unit.sv =====
// Randomised self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit;
	import rau_pkg::*;

	// Expected results of accepted fractions, oldest first
	class fraction_scoreboard;
		rau_out_t pending_results[$];
		int       fault_count;

		function bit [63:0] gcd64(input bit [63:0] a, input bit [63:0] b);
			bit [63:0] t;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			return a;
		endfunction

		// Two's-complement values kept as 65-bit signed numbers (products need 63 bits plus sign)
		function rau_out_t compute_fraction(input rau_in_t it);
			rau_out_t         r;
			logic signed [64:0] na, da, nb, db, n, d, x, y, an, ad, g;
			bit [63:0]        gg;
			r = '0;
			na = 65'(it.num_a);
			da = 65'(it.den_a);
			nb = 65'(it.num_b);
			db = 65'(it.den_b);
			if (it.cmd inside {CMD_LT, CMD_GT, CMD_EQ, CMD_NE}) begin
				if (da == 0 || db == 0) begin
					r.status = ST_ZDEN;
				end else begin
					x = na * db;
					y = nb * da;
					// multiplying through by a negative product of denominators flips order
					if ((da < 0) != (db < 0)) begin
						n = y;
						y = x;
						x = n;
					end
					case (it.cmd)
						CMD_LT: r.compare_true = x < y;
						CMD_GT: r.compare_true = x > y;
						CMD_EQ: r.compare_true = x == y;
						default: r.compare_true = x != y;
					endcase
					r.status = ST_OK;
				end
				return r;
			end
			case (it.cmd)
				CMD_ADD, CMD_SUB: begin
					if (it.cmd == CMD_SUB)
						nb = -nb;
					if (da == db) begin
						n = na + nb;
						d = da;
					end else begin
						n = na * db + nb * da;
						d = da * db;
					end
				end
				CMD_MUL: begin
					n = na * nb;
					d = da * db;
				end
				default: begin
					n = na * db;
					d = da * nb;
				end
			endcase
			if (d == 0) begin
				r.status  = ST_ZDEN;
				r.res_num = n[31:0];
				r.res_den = '0;
				return r;
			end
			an = n < 0 ? -n : n;
			ad = d < 0 ? -d : d;
			gg = gcd64(an[63:0], ad[63:0]);
			g = 65'(gg);
			n = n / g;
			d = d / g;
			// zero numerator reduces to 0/+-1 since gcd(0, d) = |d|
			if (n > 65'sd2147483647 || n < -65'sd2147483648 ||
					d > 65'sd2147483647 || d < -65'sd2147483648) begin
				r.status = ST_OVF;
			end else begin
				r.res_num = n[31:0];
				r.res_den = d[31:0];
				r.status  = ST_OK;
			end
			return r;
		endfunction

		function void note_operands(input rau_in_t it);
			pending_results.push_back(compute_fraction(it));
		endfunction

		function void check_result(input rau_out_t got);
			rau_out_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result %p", got);
				fault_count++;
				return;
			end
			want = pending_results.pop_front();
			if (got.res_num !== want.res_num) begin
				$error("res_num expected %0d actual %0d", want.res_num, got.res_num);
				fault_count++;
			end
			if (got.res_den !== want.res_den) begin
				$error("res_den expected %0d actual %0d", want.res_den, got.res_den);
				fault_count++;
			end
			if (got.compare_true !== want.compare_true) begin
				$error("compare_true expected %0b actual %0b", want.compare_true,
					got.compare_true);
				fault_count++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				fault_count++;
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 1950;

	logic     clk;
	logic     arst_n;
	logic     op_valid;
	logic     op_stall;
	rau_in_t  op;
	logic     res_valid;
	logic     res_stall;
	rau_out_t res;

	fraction_scoreboard fraction_sb;
	int  idle_cycles;
	bit  stimulus_done;

	rational_arithmetic_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.op       (op),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Interesting operand values: extremes, zero, units, small and mid-range numbers, full random words
	function logic signed [31:0] pick_value();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'sd0;
			3: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
			4, 5, 6: return 32'($signed($urandom_range(0, 200)) - 100);
			7: return 32'($signed($urandom_range(0, 70000)) - 35000);
			default: return $urandom;
		endcase
	endfunction

	// Present one item and hold it until the block takes it; valid drops only for a gap
	task automatic send_item(input rau_in_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op       <= it;
		op_valid <= 1'b1;
		do @(posedge clk); while (op_stall);
		fraction_sb.note_operands(it);
	endtask

	task automatic send_fraction(input cmd_t c, input logic signed [31:0] a,
			input logic signed [31:0] b, input logic signed [31:0] e,
			input logic signed [31:0] f);
		rau_in_t it;
		it.cmd   = c;
		it.num_a = a;
		it.den_a = b;
		it.num_b = e;
		it.den_b = f;
		send_item(it);
	endtask

	// Sender: directed corners then random items
	initial begin
		rau_in_t it;
		int      k;
		fraction_sb   = new();
		stimulus_done = 1'b0;
		op_valid      = 1'b0;
		op            = '0;
		arst_n        = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// every operation on a plain pair
		for (k = 0; k < 8; k++)
			send_fraction(cmd_t'(k), 32'sd3, 32'sd4, -32'sd5, 32'sd6);
		// like denominators, zero numerator, negative denominators
		send_fraction(CMD_ADD, 32'sd1, 32'sd4, 32'sd3, 32'sd4);
		send_fraction(CMD_SUB, 32'sd7, -32'sd3, 32'sd7, -32'sd3);
		send_fraction(CMD_LT, 32'sd1, -32'sd2, 32'sd1, 32'sd3);
		// zero denominators, compare and arithmetic, not equal included
		send_fraction(CMD_NE, 32'sd1, 32'sd0, 32'sd2, 32'sd3);
		send_fraction(CMD_ADD, 32'sd1, 32'sd0, 32'sd2, 32'sd3);
		send_fraction(CMD_DIV, 32'sd5, 32'sd2, 32'sd0, 32'sd7);
		// extreme operands: overflow cases, compares at the limits, a zero numerator product
		send_fraction(CMD_MUL, 32'sh7fff_ffff, 32'sd1, 32'sh7fff_ffff, 32'sd1);
		send_fraction(CMD_MUL, 32'sh8000_0000, 32'sd1, -32'sd1, 32'sd1);
		send_fraction(CMD_ADD, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff);
		send_fraction(CMD_DIV, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000);
		send_fraction(CMD_SUB, 32'sh8000_0000, 32'sd3, 32'sh7fff_ffff, 32'sd5);
		send_fraction(CMD_EQ, 32'sh8000_0000, 32'sh8000_0000, -32'sd1, -32'sd1);
		send_fraction(CMD_GT, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff);
		send_fraction(CMD_MUL, 32'sd0, -32'sd9, 32'sd4, 32'sd3);
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			it.cmd   = cmd_t'($urandom_range(0, 7));
			it.num_a = pick_value();
			it.den_a = pick_value();
			it.num_b = pick_value();
			it.den_b = ($urandom_range(0, 4) == 0) ? it.den_a : pick_value();
			send_item(it);
		end
		op_valid      <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Receiver: random stall, check each accepted result
	initial begin
		int gap;
		res_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			res_stall <= gap != 0;
			if (gap != 0) begin
				repeat (gap) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!res_valid);
			fraction_sb.check_result(res);
		end
	end

	// Watchdog on cycles with no accepted item in either direction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((op_valid && !op_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		while (!(stimulus_done && fraction_sb.pending_results.size() == 0) &&
				idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_rational_arithmetic_unit failed");
		end else begin
			// settle: any stray result would show up here
			repeat (400) @(posedge clk);
			if (fraction_sb.fault_count == 0 && fraction_sb.pending_results.size() == 0)
			begin
				$display("tb_rational_arithmetic_unit passed");
			end else begin
				$display("tb_rational_arithmetic_unit failed");
			end
		end
		$finish;
	end

endmodule
